// File: hw/rtl/ucc_pkg.sv
package ucc_pkg;

    // Fixed constants of the conversion
    localparam logic [26:0] DAY_MS   = 27'd86400000;
    localparam logic [41:0] MS_LIMIT = 42'd4102444800000;
    localparam logic [11:0] YEAR_FIRST = 12'd1970;
    localparam logic [11:0] YEAR_LAST  = 12'd2099;

    // Operation codes carried in s_axis_tuser
    localparam logic OP_CAL_TO_MS = 1'b0;
    localparam logic OP_MS_TO_CAL = 1'b1;

    // Calendar fields of one input beat
    typedef struct packed {
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic [2:0]  weekday;
    } cal_in_t;

    // Divider item: remainder and days quotient
    typedef struct packed {
        logic        op;
        logic        over;
        logic [42:0] rem;
        logic [15:0] quo;
    } div_t;

    // Calendar to milliseconds result
    typedef struct packed {
        logic        bad;
        logic [41:0] ms;
    } m0_res_t;

    // Milliseconds to calendar result
    typedef struct packed {
        logic        op;
        logic        bad;
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic [2:0]  weekday;
    } cal_res_t;

    // Days in month, zero for a month code out of range
    function automatic logic [4:0] month_len(input logic [3:0] mo, input logic leap);
        logic [4:0] n;
        case (mo)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: n = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                   n = 5'd30;
            4'd2:                                      n = leap ? 5'd29 : 5'd28;
            default:                                   n = 5'd0;
        endcase
        return n;
    endfunction

    // Days of the year before the first of month mo
    function automatic logic [8:0] cum_days(input logic [3:0] mo, input logic leap);
        logic [8:0] c;
        case (mo)
            4'd1:    c = 9'd0;
            4'd2:    c = 9'd31;
            4'd3:    c = 9'd59;
            4'd4:    c = 9'd90;
            4'd5:    c = 9'd120;
            4'd6:    c = 9'd151;
            4'd7:    c = 9'd181;
            4'd8:    c = 9'd212;
            4'd9:    c = 9'd243;
            4'd10:   c = 9'd273;
            4'd11:   c = 9'd304;
            4'd12:   c = 9'd334;
            default: c = 9'd0;
        endcase
        if (leap && (mo > 4'd2))
        begin
            c = c + 9'd1;
        end
        return c;
    endfunction

endpackage

// File: hw/rtl/ucc_div_step.sv
module ucc_div_step
    import ucc_pkg::*;
#(
    parameter int DIGIT = 0
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic en,
    input  logic in_valid,
    input  div_t in_item,
    output logic out_valid,
    output div_t out_item
);

    // One radix-4 digit of ms / day length
    localparam logic [42:0] D1 = 43'(DAY_MS) << (2 * DIGIT);
    localparam logic [42:0] D2 = D1 << 1;
    localparam logic [42:0] D3 = D1 + D2;

    logic        valid_reg;
    div_t        item_reg;
    div_t        item_next;

    always_comb
    begin
        item_next = in_item;
        if (in_item.rem >= D3)
        begin
            item_next.rem = in_item.rem - D3;
            item_next.quo[2*DIGIT +: 2] = 2'd3;
        end
        else if (in_item.rem >= D2)
        begin
            item_next.rem = in_item.rem - D2;
            item_next.quo[2*DIGIT +: 2] = 2'd2;
        end
        else if (in_item.rem >= D1)
        begin
            item_next.rem = in_item.rem - D1;
            item_next.quo[2*DIGIT +: 2] = 2'd1;
        end
        else
        begin
            item_next.quo[2*DIGIT +: 2] = 2'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

// File: hw/rtl/ucc_cal_to_ms.sv
module ucc_cal_to_ms
    import ucc_pkg::*;
(
    input  logic    clk,
    input  logic    en,
    input  cal_in_t cal,
    output m0_res_t res
);

    // stage 1: range checks, year offset, month offset, second of day
    logic        bad1_reg, bad1_next;
    logic [7:0]  yo1_reg, yo1_next;
    logic [8:0]  cum1_reg, cum1_next;
    logic [4:0]  dm1_reg, dm1_next;
    logic [16:0] sod1_reg, sod1_next;
    logic [2:0]  wd1_reg;

    always_comb
    begin
        logic leap;
        logic [11:0] yd;
        leap = (cal.year[1:0] == 2'b00);
        yd   = cal.year - YEAR_FIRST;
        bad1_next = (cal.year < YEAR_FIRST) || (cal.year > YEAR_LAST) ||
                    (cal.month == 4'd0) || (cal.month > 4'd12) ||
                    (cal.hour > 5'd23) || (cal.minute > 6'd59) ||
                    (cal.second > 6'd59) || (cal.day == 5'd0) ||
                    (cal.day > month_len(cal.month, leap));
        yo1_next  = yd[7:0];
        cum1_next = cum_days(cal.month, leap);
        dm1_next  = cal.day - 5'd1;
        sod1_next = 17'(cal.hour) * 17'd3600 + 17'(cal.minute) * 17'd60 +
                    17'(cal.second);
    end

    // stage 2: days since the epoch
    logic        bad2_reg;
    logic [15:0] days2_reg, days2_next;
    logic [16:0] sod2_reg;
    logic [2:0]  wd2_reg;

    always_comb
    begin
        days2_next = 16'(yo1_reg) * 16'd365 + 16'((yo1_reg + 8'd1) >> 2) +
                     16'(cum1_reg) + 16'(dm1_reg);
    end

    // stage 3: products and weekday quotient
    logic        bad3_reg;
    logic [41:0] msa3_reg;
    logic [26:0] sodms3_reg;
    logic [16:0] x3_reg;
    logic [13:0] q7_3_reg;
    logic [2:0]  wd3_reg;
    logic [42:0] msa_prod;
    logic [16:0] x_next;
    logic [33:0] q7_prod;

    always_comb
    begin
        msa_prod = 43'(days2_reg) * 43'(DAY_MS);
        x_next   = 17'(days2_reg) + 17'd3;
        q7_prod  = 34'(x_next) * 34'd74899;
    end

    // stage 4: weekday check and result
    m0_res_t     res_reg, res_next;

    always_comb
    begin
        logic [16:0] r7;
        logic [2:0]  wd;
        logic        bad;
        r7  = x3_reg - 17'(q7_3_reg) * 17'd7;
        wd  = r7[2:0] + 3'd1;
        bad = bad3_reg || (wd != wd3_reg);
        res_next.bad = bad;
        res_next.ms  = bad ? 42'd0 : msa3_reg + 42'(sodms3_reg);
    end

    // payload registers, moved by the common enable
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            bad1_reg   <= bad1_next;
            yo1_reg    <= yo1_next;
            cum1_reg   <= cum1_next;
            dm1_reg    <= dm1_next;
            sod1_reg   <= sod1_next;
            wd1_reg    <= cal.weekday;
            bad2_reg   <= bad1_reg;
            days2_reg  <= days2_next;
            sod2_reg   <= sod1_reg;
            wd2_reg    <= wd1_reg;
            bad3_reg   <= bad2_reg;
            msa3_reg   <= msa_prod[41:0];
            sodms3_reg <= 27'(sod2_reg) * 27'd1000;
            x3_reg     <= x_next;
            q7_3_reg   <= q7_prod[32:19];
            wd3_reg    <= wd2_reg;
            res_reg    <= res_next;
        end
    end

    assign res = res_reg;

endmodule

// File: hw/rtl/ucc_ms_to_cal.sv
module ucc_ms_to_cal
    import ucc_pkg::*;
(
    input  logic     clk,
    input  logic     en,
    input  div_t     in_item,
    output cal_res_t res
);

    // stage a: reciprocal products for /1000, /1461 and /7
    logic        op_a_reg, over_a_reg;
    logic [26:0] r_a_reg;
    logic [15:0] days_a_reg;
    logic [16:0] q1000_a_reg;
    logic [5:0]  q1461_a_reg;
    logic [16:0] x_a_reg;
    logic [13:0] q7_a_reg;
    logic [54:0] p1000;
    logic [32:0] p1461;
    logic [16:0] x_next;
    logic [33:0] p7;

    always_comb
    begin
        p1000  = 55'(in_item.rem[26:0]) * 55'd137438954;
        p1461  = 33'(in_item.quo) * 33'd91868;
        x_next = 17'(in_item.quo) + 17'd3;
        p7     = 34'(x_next) * 34'd74899;
    end

    // stage b: remainders, weekday, fraction check
    logic        op_b_reg, bad_b_reg, bad_b_next;
    logic [16:0] sod_b_reg;
    logic [10:0] r1461_b_reg, r1461_next;
    logic [5:0]  q1461_b_reg;
    logic [2:0]  wd_b_reg, wd_next;

    always_comb
    begin
        logic [26:0] m1000;
        logic [15:0] m1461;
        logic [16:0] r7;
        m1000      = 27'(q1000_a_reg) * 27'd1000;
        m1461      = 16'(q1461_a_reg) * 16'd1461;
        r7         = x_a_reg - 17'(q7_a_reg) * 17'd7;
        m1461      = days_a_reg - m1461;
        r1461_next = m1461[10:0];
        wd_next    = r7[2:0] + 3'd1;
        bad_b_next = over_a_reg || (m1000 != r_a_reg);
    end

    // stage c: year within the four-year cycle, hour
    logic        op_c_reg, bad_c_reg, leap_c_reg, leap_next;
    logic [11:0] year_c_reg, year_next;
    logic [8:0]  doy_c_reg, doy_next;
    logic [4:0]  hour_c_reg, hour_next;
    logic [11:0] r3600_c_reg, r3600_next;
    logic [2:0]  wd_c_reg;

    always_comb
    begin
        logic [1:0]  idx;
        logic [16:0] r;
        if (r1461_b_reg < 11'd365)
        begin
            idx = 2'd0;
            doy_next = r1461_b_reg[8:0];
        end
        else if (r1461_b_reg < 11'd730)
        begin
            idx = 2'd1;
            doy_next = 9'(r1461_b_reg - 11'd365);
        end
        else if (r1461_b_reg < 11'd1096)
        begin
            idx = 2'd2;
            doy_next = 9'(r1461_b_reg - 11'd730);
        end
        else
        begin
            idx = 2'd3;
            doy_next = 9'(r1461_b_reg - 11'd1096);
        end
        leap_next = (idx == 2'd2);
        year_next = YEAR_FIRST + {4'd0, q1461_b_reg, 2'b00} + 12'(idx);
        // restoring steps for the hour
        r = sod_b_reg;
        hour_next = 5'd0;
        for (int i = 4; i >= 0; i--)
        begin
            if (r >= (17'd3600 << i))
            begin
                r = r - (17'd3600 << i);
                hour_next[i] = 1'b1;
            end
        end
        r3600_next = r[11:0];
    end

    // stage d: month, minute and second
    logic        op_d_reg, bad_d_reg, leap_d_reg;
    logic [11:0] year_d_reg;
    logic [8:0]  doy_d_reg;
    logic [3:0]  mo_d_reg, mo_next;
    logic [4:0]  hour_d_reg;
    logic [5:0]  min_d_reg, min_next;
    logic [5:0]  sec_d_reg;
    logic [2:0]  wd_d_reg;
    logic [11:0] rmin;

    always_comb
    begin
        mo_next = 4'd1;
        for (int m = 2; m <= 12; m++)
        begin
            if (doy_c_reg >= cum_days(4'(m), leap_c_reg))
            begin
                mo_next = mo_next + 4'd1;
            end
        end
        rmin = r3600_c_reg;
        min_next = 6'd0;
        for (int i = 5; i >= 0; i--)
        begin
            if (rmin >= (12'd60 << i))
            begin
                rmin = rmin - (12'd60 << i);
                min_next[i] = 1'b1;
            end
        end
    end

    // stage e: day of month and result
    cal_res_t    res_reg, res_next;

    always_comb
    begin
        logic [8:0] dd;
        dd = doy_d_reg - cum_days(mo_d_reg, leap_d_reg) + 9'd1;
        res_next = '0;
        res_next.op  = op_d_reg;
        res_next.bad = bad_d_reg;
        if (op_d_reg && !bad_d_reg)
        begin
            res_next.year    = year_d_reg;
            res_next.month   = mo_d_reg;
            res_next.day     = dd[4:0];
            res_next.hour    = hour_d_reg;
            res_next.minute  = min_d_reg;
            res_next.second  = sec_d_reg;
            res_next.weekday = wd_d_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            op_a_reg    <= in_item.op;
            over_a_reg  <= in_item.over;
            r_a_reg     <= in_item.rem[26:0];
            days_a_reg  <= in_item.quo;
            q1000_a_reg <= p1000[53:37];
            q1461_a_reg <= p1461[32:27];
            x_a_reg     <= x_next;
            q7_a_reg    <= p7[32:19];

            op_b_reg    <= op_a_reg;
            bad_b_reg   <= bad_b_next;
            sod_b_reg   <= q1000_a_reg;
            r1461_b_reg <= r1461_next;
            q1461_b_reg <= q1461_a_reg;
            wd_b_reg    <= wd_next;

            op_c_reg    <= op_b_reg;
            bad_c_reg   <= bad_b_reg;
            leap_c_reg  <= leap_next;
            year_c_reg  <= year_next;
            doy_c_reg   <= doy_next;
            hour_c_reg  <= hour_next;
            r3600_c_reg <= r3600_next;
            wd_c_reg    <= wd_b_reg;

            op_d_reg    <= op_c_reg;
            bad_d_reg   <= bad_c_reg;
            leap_d_reg  <= leap_c_reg;
            year_d_reg  <= year_c_reg;
            doy_d_reg   <= doy_c_reg;
            mo_d_reg    <= mo_next;
            hour_d_reg  <= hour_c_reg;
            min_d_reg   <= min_next;
            sec_d_reg   <= rmin[5:0];
            wd_d_reg    <= wd_c_reg;

            res_reg     <= res_next;
        end
    end

    assign res = res_reg;

endmodule

// File: hw/rtl/unix_ms_calendar_converter.sv
// Channel   Dir  tdata (88 bits)                              tuser
// s_axis    in   unix_ms, year, month, day, hour, min, sec, wd operation
// m_axis    out  unix_ms, year, month, day, hour, min, sec, wd status
//
// Thirteen register stages; a beat may enter every cycle while m_axis is
// not stalled. Depth is set by the eight radix-4 stages that divide
// milliseconds by the day length, followed by five calendar stages.
// Reset clears the valid bits only. A stall on m_axis freezes the whole
// pipeline, so nothing is dropped or repeated.
module unix_ms_calendar_converter
    import ucc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [41:0] in_unix_ms, [53:42] in_year, [57:54] in_month, [62:58] in_day,
    // [67:63] in_hour, [73:68] in_minute, [79:74] in_second, [82:80] in_weekday
    input  logic [87:0] s_axis_tdata,
    // [0] operation
    input  logic        s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [41:0] epoch_ms, [53:42] out_year, [57:54] out_month, [62:58] out_day,
    // [67:63] out_hour, [73:68] out_minute, [79:74] out_second,
    // [82:80] out_weekday
    output logic [87:0] m_axis_tdata,
    // [0] status
    output logic        m_axis_tuser
);

    localparam int NDIV   = 8;
    localparam int NCAL   = 5;
    localparam int NDEPTH = NDIV + NCAL;
    localparam int NM0    = 4;
    localparam int NDLY   = NDEPTH - NM0;

    logic en;
    logic [NDEPTH-1:0] vld_reg;

    // common advance: move whenever the output register is free
    assign en            = !vld_reg[NDEPTH-1] || m_axis_tready;
    assign s_axis_tready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[NDEPTH-2:0], s_axis_tvalid};
        end
    end

    // calendar to milliseconds path
    cal_in_t cal;
    m0_res_t m0_res;

    assign cal.year    = s_axis_tdata[53:42];
    assign cal.month   = s_axis_tdata[57:54];
    assign cal.day     = s_axis_tdata[62:58];
    assign cal.hour    = s_axis_tdata[67:63];
    assign cal.minute  = s_axis_tdata[73:68];
    assign cal.second  = s_axis_tdata[79:74];
    assign cal.weekday = s_axis_tdata[82:80];

    ucc_cal_to_ms u_cal_to_ms
    (
        .clk   (clk),
        .en    (en),
        .cal   (cal),
        .res   (m0_res)
    );

    // align with the longer path
    m0_res_t m0_dly_reg [NDLY];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m0_dly_reg[0] <= m0_res;
            for (int i = 1; i < NDLY; i++)
            begin
                m0_dly_reg[i] <= m0_dly_reg[i-1];
            end
        end
    end

    // milliseconds to days divider
    div_t div_in;
    div_t div_item [NDIV+1];
    logic [NDIV:0] div_vld;

    assign div_in.op   = s_axis_tuser;
    assign div_in.over = (s_axis_tdata[41:0] >= MS_LIMIT);
    assign div_in.rem  = {1'b0, s_axis_tdata[41:0]};
    assign div_in.quo  = '0;
    assign div_item[0] = div_in;
    assign div_vld[0]  = s_axis_tvalid;

    for (genvar g = 0; g < NDIV; g++)
    begin : g_div
        ucc_div_step #(.DIGIT(NDIV - 1 - g)) u_step
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (div_vld[g]),
            .in_item   (div_item[g]),
            .out_valid (div_vld[g+1]),
            .out_item  (div_item[g+1])
        );
    end

    // days and remainder to calendar
    cal_res_t cal_res;

    ucc_ms_to_cal u_ms_to_cal
    (
        .clk     (clk),
        .en      (en),
        .in_item (div_item[NDIV]),
        .res     (cal_res)
    );

    // output beat
    m0_res_t m0_out;
    assign m0_out = m0_dly_reg[NDLY-1];

    assign m_axis_tvalid = vld_reg[NDEPTH-1] && div_vld[NDIV] | vld_reg[NDEPTH-1];
    assign m_axis_tuser  = cal_res.op ? cal_res.bad : m0_out.bad;
    assign m_axis_tdata  = {5'd0, cal_res.weekday, cal_res.second, cal_res.minute,
                            cal_res.hour, cal_res.day, cal_res.month, cal_res.year,
                            (cal_res.op ? 42'd0 : m0_out.ms)};

endmodule

// File: tb/sv/ucc_checker.sv
module ucc_checker
    import ucc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [87:0] s_axis_tdata,
    input  logic        s_axis_tuser,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [87:0] m_axis_tdata,
    input  logic        m_axis_tuser,
    output int          fail_count,
    output int          pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [41:0] MS_END = 42'd4102444800000;

    // Expected result beat: status in bit 88, tdata below
    logic [88:0] conversion_q[$];

    function automatic bit is_leap(int y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function automatic int days_in_month(int y, int m);
        int n;
        case (m)
            1, 3, 5, 7, 8, 10, 12: n = 31;
            4, 6, 9, 11:           n = 30;
            2:                     n = is_leap(y) ? 29 : 28;
            default:               n = 0;
        endcase
        return n;
    endfunction

    // Expected beat for one accepted input beat
    function automatic logic [88:0] convert(logic op, logic [87:0] d);
        logic [88:0] r;
        longint unsigned ms, secs, days, all_days, rem;
        int y, mo, dd, h, mi, s, wd, k;
        r = '0;
        if (op == OP_CAL_TO_MS)
        begin
            y = int'(d[53:42]); mo = int'(d[57:54]); dd = int'(d[62:58]);
            h = int'(d[67:63]); mi = int'(d[73:68]); s = int'(d[79:74]);
            wd = int'(d[82:80]);
            if (y < 1970 || y > 2099 || mo < 1 || mo > 12 || h > 23 || mi > 59
                || s > 59 || dd == 0 || dd > days_in_month(y, mo))
            begin
                r[88] = 1'b1;
                return r;
            end
            days = 0;
            for (k = 1970; k < y; k++)
                days += is_leap(k) ? 366 : 365;
            for (k = 1; k < mo; k++)
                days += days_in_month(y, k);
            days += dd - 1;
            if (wd != int'((days + 3) % 7) + 1)
            begin
                r[88] = 1'b1;
                return r;
            end
            ms = (days * 86400 + h * 3600 + mi * 60 + s) * 1000;
            r[41:0] = ms[41:0];
        end
        else
        begin
            ms = {22'd0, d[41:0]};
            if (ms % 1000 != 0 || ms >= MS_END)
            begin
                r[88] = 1'b1;
                return r;
            end
            secs = ms / 1000;
            all_days = secs / 86400;
            rem = secs % 86400;
            days = all_days;
            y = 1970;
            while (y < 2099 && days >= (is_leap(y) ? 366 : 365))
            begin
                days -= is_leap(y) ? 366 : 365;
                y++;
            end
            mo = 1;
            while (mo < 12 && days >= days_in_month(y, mo))
            begin
                days -= days_in_month(y, mo);
                mo++;
            end
            r[53:42] = 12'(y);
            r[57:54] = 4'(mo);
            r[62:58] = 5'(days + 1);
            r[67:63] = 5'(rem / 3600);
            r[73:68] = 6'((rem % 3600) / 60);
            r[79:74] = 6'(rem % 60);
            r[82:80] = 3'((all_days + 3) % 7 + 1);
        end
        return r;
    endfunction

    initial fail_count = 0;
    assign pending_count = conversion_q.size();

    // Predict on input beats, compare on output beats
    always @(posedge clk)
    begin
        logic [88:0] want;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (conversion_q.size() == 0)
                begin
                    $display("%0t: unexpected beat status=%0b data=%h", $time,
                             m_axis_tuser, m_axis_tdata);
                    fail_count++;
                end
                else
                begin
                    want = conversion_q.pop_front();
                    if (want[88] !== m_axis_tuser)
                    begin
                        $display("%0t: status expected %0b actual %0b", $time,
                                 want[88], m_axis_tuser);
                        fail_count++;
                    end
                    if (want[87:0] !== m_axis_tdata)
                    begin
                        $display("%0t: data expected %h actual %h", $time,
                                 want[87:0], m_axis_tdata);
                        fail_count++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                conversion_q.push_back(convert(s_axis_tuser, s_axis_tdata));
        end
    end
endmodule

// File: tb/sv/tb.sv
module tb
    import ucc_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 400000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [87:0] s_axis_tdata = '0;
    logic        s_axis_tuser = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [87:0] m_axis_tdata;
    logic        m_axis_tuser;
    int          fail_count;
    int          pending_count;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          cycles = 0;

    always #5 clk = ~clk;

    unix_ms_calendar_converter uut (.*);
    ucc_checker chk (.*);

    // Receiver stalls at random
    always @(negedge clk)
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);

    // Watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb NOT OK");
            $finish;
        end
    end

    function automatic int month_len(int y, int m);
        if (m == 2)
            return (((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0)) ? 29 : 28;
        return (m == 4 || m == 6 || m == 9 || m == 11) ? 30 : 31;
    endfunction

    function automatic int weekday_of(int y, int m, int d);
        longint days;
        int k;
        days = 0;
        for (k = 1970; k < y; k++)
            days += month_len(k, 2) == 29 ? 366 : 365;
        for (k = 1; k < m; k++)
            days += month_len(y, k);
        days += d - 1;
        return int'((days + 3) % 7) + 1;
    endfunction

    // One beat; random gap first, held until accepted
    task automatic send(logic op, logic [87:0] d);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= d;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_cal(int y, int mo, int d, int h, int mi, int s, int wd);
        logic [87:0] p;
        p = 88'({$urandom, $urandom, $urandom});
        p[41:0] = 42'({$urandom, $urandom});
        p[53:42] = 12'(y); p[57:54] = 4'(mo); p[62:58] = 5'(d); p[67:63] = 5'(h);
        p[73:68] = 6'(mi); p[79:74] = 6'(s); p[82:80] = 3'(wd); p[87:83] = '0;
        send(OP_CAL_TO_MS, p);
    endtask

    task automatic send_ms(longint unsigned ms);
        logic [87:0] p;
        p = 88'({$urandom, $urandom, $urandom});
        p[41:0] = ms[41:0];
        p[87:83] = '0;
        send(OP_MS_TO_CAL, p);
    endtask

    // Well-formed date with random content, sometimes a broken field, or a millisecond value in or out of range
    task automatic random_beat();
        int y, mo, d, wd, r;
        r = $urandom_range(99);
        y = $urandom_range(2099, 1970); mo = $urandom_range(12, 1);
        d = $urandom_range(month_len(y, mo), 1);
        wd = weekday_of(y, mo, d);
        if (r < 40)
            send_cal(y, mo, d, $urandom_range(23), $urandom_range(59),
                     $urandom_range(59), wd);
        else if (r < 55)
        begin
            case ($urandom_range(6))
                0: y = $urandom_range(4095);
                1: mo = $urandom_range(15);
                2: d = $urandom_range(31);
                3: wd = $urandom_range(7);
                default: d = month_len(y, mo) + 1;
            endcase
            send_cal(y, mo, d, $urandom_range(31), $urandom_range(63),
                     $urandom_range(63), wd);
        end
        else if (r < 90)
            send_ms(longint'($urandom_range(32'hFFFFFFFF)) * 1000 % 64'd4102444800000);
        else if (r < 95)
            send_ms(longint'($urandom_range(32'hFFFFFFFF)) * 1000 + 64'd4102444800000);
        else
            send_ms({$urandom, $urandom} & 64'h3FFFFFFFFFF);
    endtask

    initial
    begin
        int ph, i;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: extremes and special cases
        send_cal(1970, 1, 1, 0, 0, 0, 4);
        send_cal(2099, 12, 31, 23, 59, 59, 4);
        send_cal(2000, 2, 29, 12, 30, 30, weekday_of(2000, 2, 29));
        send_cal(2024, 2, 29, 0, 0, 0, weekday_of(2024, 2, 29));
        send_cal(2023, 2, 29, 0, 0, 0, 3);
        send_cal(1969, 12, 31, 23, 59, 59, 3);
        send_cal(2100, 1, 1, 0, 0, 0, 5);
        send_cal(4095, 15, 31, 31, 63, 63, 7);
        send_cal(0, 0, 0, 0, 0, 0, 0);
        send_cal(2020, 13, 1, 0, 0, 0, 1);
        send_cal(2020, 4, 31, 0, 0, 0, 5);
        send_cal(2020, 1, 1, 24, 0, 0, 3);
        send_cal(2020, 1, 1, 0, 60, 0, 3);
        send_cal(2020, 1, 1, 0, 0, 60, 3);
        send_cal(2020, 1, 1, 0, 0, 0, 4);
        send_cal(2020, 1, 1, 0, 0, 0, 0);
        send_ms(0);
        send_ms(64'd4102444799000);
        send_ms(64'd4102444800000);
        send_ms(64'd4102444799999);
        send_ms(64'd1);
        send_ms(64'h3FFFFFFFFFF);
        send_ms(64'd951782400000);
        send_ms(64'd4107542399000);

        // Random phases with different idling
        for (ph = 0; ph < 5; ph++)
        begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 77; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 77; end
                3: begin send_idle_pct = 14; recv_stall_pct = 14; end
                default: begin send_idle_pct = 0; recv_stall_pct = 0; end
            endcase
            for (i = 0; i < 360; i++)
                random_beat();
        end
        s_axis_tvalid <= 1'b0;

        while (pending_count != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
        if (fail_count == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end
endmodule

// File: files.f
hw/rtl/ucc_pkg.sv
hw/rtl/ucc_div_step.sv
hw/rtl/ucc_cal_to_ms.sv
hw/rtl/ucc_ms_to_cal.sv
hw/rtl/unix_ms_calendar_converter.sv
tb/sv/ucc_checker.sv
tb/sv/tb.sv
